@@ design/tked_pkg.sv @@
`timescale 1ns / 1ps
// Package for the terminal escape key decoder.
// Holds the character codes, key and phase encodings, and the state structs
// shared by the step logic, the field parser and the top level.
package tked_pkg;

  localparam int SEQ_MAX = 31;
  localparam int LEN_W = $clog2(SEQ_MAX + 1);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_UPPER_O = 8'h4F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LESS = 8'h3C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_B = 8'h42;
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] CH_UPPER_D = 8'h44;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_H = 8'h48;
  localparam logic [7:0] CH_UPPER_M = 8'h4D;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  localparam logic [7:0] X10_BUTTON_BASE = 8'd32;
  localparam logic [7:0] X10_COORD_BASE = 8'd33;

  typedef enum logic [4:0] {
    KEY_BYTE,
    KEY_ESC,
    KEY_UP,
    KEY_DOWN,
    KEY_RIGHT,
    KEY_LEFT,
    KEY_LINE_START,
    KEY_END,
    KEY_DEL,
    KEY_PGUP,
    KEY_PGDN,
    KEY_CTRL_PGUP,
    KEY_CTRL_PGDN,
    KEY_CTL_ALT_UP,
    KEY_CTRL_ALT_DN,
    KEY_NEXT_WORD,
    KEY_PREV_WORD,
    KEY_CLICK_LEFT,
    KEY_CLICK_RIGHT,
    KEY_WHEEL_UP,
    KEY_WHEEL_DN,
    KEY_ALT_CLICK_LEFT
  } key_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_SS3,
    PH_CSI,
    PH_X10
  } phase_t;

  typedef struct packed {
    logic [2:0][15:0] value;
    logic [2:0]       cursor;
    logic [2:0][7:0]  stop_char;
  } field_state_t;

  typedef struct packed {
    phase_t             phase;
    logic [LEN_W-1:0]   seq_length;
    logic [7:0]         first_byte;
    field_state_t       fld;
    logic [1:0]         x10_count;
    logic signed [16:0] mouse_x;
    logic signed [16:0] mouse_y;
  } parse_state_t;

  typedef struct packed {
    logic      valid;
    key_kind_t kind;
    logic [7:0] key_byte;
  } key_result_t;

  typedef struct packed {
    logic en;
    logic idx;
  } x10_write_t;

endpackage

@@ design/tked_field.sv @@
`timescale 1ns / 1ps
// Incremental parser for the numeric fields of a CSI body.
// Depends on tked_pkg for the field state struct and character codes.
module tked_field (
  input  logic                  en,
  input  logic [7:0]            c,
  input  logic [1:0]            last_field,
  input  tked_pkg::field_state_t fld,
  output tked_pkg::field_state_t fld_next
);

  logic [1:0]  k;
  logic [19:0] prod;
  logic [15:0] sat;

  assign k = (fld.cursor[1:0] > 2'd2) ? 2'd2 : fld.cursor[1:0];

  always_comb begin
    prod = {4'd0, fld.value[k]} * 20'd10 + {12'd0, c - tked_pkg::CH_ZERO};
    sat = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
  end

  always_comb begin
    fld_next = fld;
    if (en && !fld.cursor[2]) begin
      if (c >= tked_pkg::CH_ZERO && c <= tked_pkg::CH_NINE) begin
        fld_next.value[k] = sat;
      end else if (c == tked_pkg::CH_SEMI && k < last_field) begin
        fld_next.stop_char[k] = c;
        fld_next.cursor = {1'b0, k} + 3'd1;
      end else begin
        fld_next.stop_char[k] = c;
        fld_next.cursor = {1'b1, k};
      end
    end
  end

endmodule

@@ design/tked_step.sv @@
`timescale 1ns / 1ps
// Next-state and result logic for one input word of the key decoder.
// Depends on tked_pkg and instantiates tked_field for the CSI body.
module tked_step (
  input  tked_pkg::parse_state_t st,
  input  logic                   timeout,
  input  logic [7:0]             b,
  input  logic [1:0][7:0]        x10_bytes,
  output tked_pkg::parse_state_t st_next,
  output tked_pkg::x10_write_t   x10_wr,
  output tked_pkg::key_result_t  res
);

  logic                        feed_en;
  logic [1:0]                  last_field;
  tked_pkg::field_state_t      fld_fed;
  logic [tked_pkg::LEN_W-1:0]  len_new;
  logic [7:0]                  first_new;
  logic                        end_byte;
  logic                        csi_done;
  logic [tked_pkg::LEN_W-1:0]  f_len;
  logic [7:0]                  f_first;
  tked_pkg::field_state_t      f_fld;
  logic [1:0]                  f_k;
  logic [1:0]                  f_kc;
  logic [7:0]                  f_stop;
  logic                        fin_x10;
  logic                        fin_mouse;
  tked_pkg::key_result_t       fin_res;
  tked_pkg::key_result_t       num_res;
  tked_pkg::key_result_t       x10_res;
  logic signed [16:0]          x10_col;
  logic signed [16:0]          x10_row;
  logic [15:0]                 x10_btn;

  function automatic tked_pkg::key_result_t key_of(input tked_pkg::key_kind_t kind);
    tked_pkg::key_result_t r;
    r.valid = 1'b1;
    r.kind = kind;
    r.key_byte = 8'd0;
    return r;
  endfunction

  function automatic tked_pkg::key_result_t button_kind(input logic [15:0] btn,
                                                        input logic sgr);
    tked_pkg::key_result_t r;
    r = key_of(tked_pkg::KEY_ESC);
    if (btn == 16'd64) begin
      r.kind = tked_pkg::KEY_WHEEL_UP;
    end else if (btn == 16'd65) begin
      r.kind = tked_pkg::KEY_WHEEL_DN;
    end else if (btn == 16'd0) begin
      r.kind = tked_pkg::KEY_CLICK_LEFT;
    end else if (btn == 16'd2) begin
      r.kind = tked_pkg::KEY_CLICK_RIGHT;
    end else if (sgr && (btn == 16'd8 || btn == 16'd16 || btn == 16'd24)) begin
      r.kind = tked_pkg::KEY_ALT_CLICK_LEFT;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [16:0] x10_coord(input logic [7:0] v);
    return (v >= tked_pkg::X10_COORD_BASE) ? {9'd0, v - tked_pkg::X10_COORD_BASE} : 17'sd0;
  endfunction

  assign feed_en = (st.phase == tked_pkg::PH_CSI) && !timeout &&
                   ((st.seq_length != '0) || (b != tked_pkg::CH_LESS));
  assign last_field = (st.seq_length != '0 && st.first_byte == tked_pkg::CH_LESS) ?
                      2'd2 : 2'd1;

  tked_field u_field (
    .en        (feed_en),
    .c         (b),
    .last_field(last_field),
    .fld       (st.fld),
    .fld_next  (fld_fed)
  );

  assign len_new = st.seq_length + tked_pkg::LEN_W'(1);
  assign first_new = (st.seq_length == '0) ? b : st.first_byte;
  assign end_byte = (b >= tked_pkg::CH_UPPER_A && b <= tked_pkg::CH_UPPER_Z) ||
                    (b >= tked_pkg::CH_LOWER_A && b <= tked_pkg::CH_LOWER_Z) ||
                    (b == tked_pkg::CH_TILDE) ||
                    ({1'b0, len_new} >= (tked_pkg::LEN_W + 1)'(tked_pkg::SEQ_MAX));
  assign csi_done = timeout || end_byte;

  assign f_len = timeout ? st.seq_length : len_new;
  assign f_first = timeout ? st.first_byte : first_new;
  assign f_fld = timeout ? st.fld : fld_fed;
  assign f_k = f_fld.cursor[1:0];
  assign f_kc = (f_k > 2'd2) ? 2'd2 : f_k;
  assign f_stop = f_fld.stop_char[f_kc];

  always_comb begin
    num_res = key_of(tked_pkg::KEY_ESC);
    if (f_fld.cursor[2] && f_k <= 2'd1) begin
      if (f_k == 2'd0) begin
        if (f_stop == tked_pkg::CH_TILDE) begin
          unique case (f_fld.value[0])
            16'd1, 16'd7: num_res.kind = tked_pkg::KEY_LINE_START;
            16'd3:        num_res.kind = tked_pkg::KEY_DEL;
            16'd4, 16'd8: num_res.kind = tked_pkg::KEY_END;
            16'd5:        num_res.kind = tked_pkg::KEY_PGUP;
            16'd6:        num_res.kind = tked_pkg::KEY_PGDN;
            default:      num_res.kind = tked_pkg::KEY_ESC;
          endcase
        end
      end else begin
        priority if (f_stop == tked_pkg::CH_TILDE && f_fld.value[0] == 16'd5 &&
                     (f_fld.value[1] == 16'd5 || f_fld.value[1] == 16'd6)) begin
          num_res.kind = tked_pkg::KEY_CTRL_PGUP;
        end else if (f_stop == tked_pkg::CH_TILDE && f_fld.value[0] == 16'd6 &&
                     (f_fld.value[1] == 16'd5 || f_fld.value[1] == 16'd6)) begin
          num_res.kind = tked_pkg::KEY_CTRL_PGDN;
        end else if (f_fld.value[1] == 16'd7 && f_stop == tked_pkg::CH_UPPER_A) begin
          num_res.kind = tked_pkg::KEY_CTL_ALT_UP;
        end else if (f_fld.value[1] == 16'd7 && f_stop == tked_pkg::CH_UPPER_B) begin
          num_res.kind = tked_pkg::KEY_CTRL_ALT_DN;
        end else if ((f_fld.value[1] == 16'd5 || f_fld.value[1] == 16'd6) &&
                     f_stop == tked_pkg::CH_UPPER_C) begin
          num_res.kind = tked_pkg::KEY_NEXT_WORD;
        end else if ((f_fld.value[1] == 16'd5 || f_fld.value[1] == 16'd6) &&
                     f_stop == tked_pkg::CH_UPPER_D) begin
          num_res.kind = tked_pkg::KEY_PREV_WORD;
        end else if (f_stop == tked_pkg::CH_UPPER_A) begin
          num_res.kind = tked_pkg::KEY_UP;
        end else if (f_stop == tked_pkg::CH_UPPER_B) begin
          num_res.kind = tked_pkg::KEY_DOWN;
        end else if (f_stop == tked_pkg::CH_UPPER_C) begin
          num_res.kind = tked_pkg::KEY_RIGHT;
        end else if (f_stop == tked_pkg::CH_UPPER_D) begin
          num_res.kind = tked_pkg::KEY_LEFT;
        end else begin
          num_res.kind = tked_pkg::KEY_ESC;
        end
      end
    end
  end

  always_comb begin
    fin_x10 = 1'b0;
    fin_mouse = 1'b0;
    fin_res = key_of(tked_pkg::KEY_ESC);
    priority if (f_len == '0) begin
      fin_res = key_of(tked_pkg::KEY_ESC);
    end else if (f_first == tked_pkg::CH_UPPER_M && f_len == tked_pkg::LEN_W'(1)) begin
      fin_x10 = 1'b1;
      fin_res.valid = 1'b0;
    end else if (f_first == tked_pkg::CH_LESS) begin
      if (f_fld.cursor[2] && f_stop == tked_pkg::CH_UPPER_M) begin
        fin_mouse = 1'b1;
        fin_res = button_kind(f_fld.value[0], 1'b1);
      end else begin
        fin_res.valid = 1'b0;
      end
    end else if (f_len == tked_pkg::LEN_W'(1) && f_first >= tked_pkg::CH_UPPER_A) begin
      unique case (f_first)
        tked_pkg::CH_UPPER_A: fin_res.kind = tked_pkg::KEY_UP;
        tked_pkg::CH_UPPER_B: fin_res.kind = tked_pkg::KEY_DOWN;
        tked_pkg::CH_UPPER_C: fin_res.kind = tked_pkg::KEY_RIGHT;
        tked_pkg::CH_UPPER_D: fin_res.kind = tked_pkg::KEY_LEFT;
        tked_pkg::CH_UPPER_H: fin_res.kind = tked_pkg::KEY_LINE_START;
        tked_pkg::CH_UPPER_F: fin_res.kind = tked_pkg::KEY_END;
        default:              fin_res.kind = tked_pkg::KEY_ESC;
      endcase
    end else begin
      fin_res = num_res;
    end
  end

  assign x10_btn = (x10_bytes[0] >= tked_pkg::X10_BUTTON_BASE) ?
                   {8'd0, x10_bytes[0] - tked_pkg::X10_BUTTON_BASE} : 16'hFFFF;
  assign x10_res = button_kind(x10_btn, 1'b0);
  assign x10_col = x10_coord(x10_bytes[1]);
  assign x10_row = x10_coord(b);

  always_comb begin
    st_next = st;
    x10_wr.en = 1'b0;
    x10_wr.idx = st.x10_count[0];
    unique case (st.phase)
      tked_pkg::PH_IDLE: begin
        if (!timeout && b == tked_pkg::CH_ESC) begin
          st_next.phase = tked_pkg::PH_ESC;
        end
      end
      tked_pkg::PH_ESC: begin
        st_next.phase = tked_pkg::PH_IDLE;
        if (!timeout && b == tked_pkg::CH_LBRACKET) begin
          st_next.phase = tked_pkg::PH_CSI;
          st_next.seq_length = '0;
          st_next.first_byte = 8'd0;
          st_next.fld = '0;
        end else if (!timeout && b == tked_pkg::CH_UPPER_O) begin
          st_next.phase = tked_pkg::PH_SS3;
        end
      end
      tked_pkg::PH_SS3: begin
        st_next.phase = tked_pkg::PH_IDLE;
      end
      tked_pkg::PH_CSI: begin
        if (!timeout) begin
          st_next.seq_length = len_new;
          st_next.first_byte = first_new;
          st_next.fld = fld_fed;
        end
        if (csi_done) begin
          st_next.phase = fin_x10 ? tked_pkg::PH_X10 : tked_pkg::PH_IDLE;
          if (fin_x10) begin
            st_next.x10_count = 2'd0;
          end
          if (fin_mouse) begin
            st_next.mouse_x = $signed({1'b0, f_fld.value[1]}) - 17'sd1;
            st_next.mouse_y = $signed({1'b0, f_fld.value[2]}) - 17'sd1;
          end
        end
      end
      tked_pkg::PH_X10: begin
        if (timeout) begin
          st_next.phase = tked_pkg::PH_IDLE;
          st_next.x10_count = 2'd0;
        end else if (st.x10_count < 2'd2) begin
          x10_wr.en = 1'b1;
          st_next.x10_count = st.x10_count + 2'd1;
        end else begin
          st_next.phase = tked_pkg::PH_IDLE;
          st_next.x10_count = 2'd0;
          st_next.mouse_x = x10_col;
          st_next.mouse_y = x10_row;
        end
      end
      default: begin
        st_next.phase = tked_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res.valid = 1'b0;
    res.kind = tked_pkg::KEY_BYTE;
    res.key_byte = 8'd0;
    unique case (st.phase)
      tked_pkg::PH_IDLE: begin
        if (!timeout && b != tked_pkg::CH_NUL && b != tked_pkg::CH_ESC) begin
          res.valid = 1'b1;
          res.key_byte = b;
        end
      end
      tked_pkg::PH_ESC: begin
        if (timeout || (b != tked_pkg::CH_LBRACKET && b != tked_pkg::CH_UPPER_O)) begin
          res = key_of(tked_pkg::KEY_ESC);
        end
      end
      tked_pkg::PH_SS3: begin
        res = key_of(tked_pkg::KEY_ESC);
        if (!timeout) begin
          unique case (b)
            tked_pkg::CH_UPPER_H: res.kind = tked_pkg::KEY_LINE_START;
            tked_pkg::CH_UPPER_F: res.kind = tked_pkg::KEY_END;
            tked_pkg::CH_LOWER_C: res.kind = tked_pkg::KEY_NEXT_WORD;
            tked_pkg::CH_LOWER_D: res.kind = tked_pkg::KEY_PREV_WORD;
            default:              res.kind = tked_pkg::KEY_ESC;
          endcase
        end
      end
      tked_pkg::PH_CSI: begin
        if (csi_done) begin
          res = fin_res;
        end
      end
      tked_pkg::PH_X10: begin
        if (!timeout && st.x10_count >= 2'd2) begin
          res = x10_res;
        end
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

endmodule

@@ design/terminal_escape_key_decoder.sv @@
`timescale 1ns / 1ps
// Terminal escape key decoder: turns terminal bytes and read timeouts into key events.
// An accepted word waits in the input register until the result register is empty or being
// read; then the step logic decodes it into the parse state and result register. Throughput
// is one word per cycle, set by the single decode step between the input register and the
// result register; a key event held by the receiver stalls the input once the input
// register fills. Synchronous reset clears the parse state and drops words in flight.
module terminal_escape_key_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         key_kind,
  output logic [7:0]         key_byte,
  output logic signed [16:0] pointer_column,
  output logic signed [16:0] pointer_row
);

  logic                   in_full;
  logic                   in_op;
  logic [7:0]             in_byte;
  logic                   advance;
  tked_pkg::parse_state_t st;
  tked_pkg::parse_state_t st_next;
  logic [1:0][7:0]        x10_bytes;
  tked_pkg::x10_write_t   x10_wr;
  tked_pkg::key_result_t  res;

  assign advance = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  tked_step u_step (
    .st       (st),
    .timeout  (in_op),
    .b        (in_byte),
    .x10_bytes(x10_bytes),
    .st_next  (st_next),
    .x10_wr   (x10_wr),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op <= operation;
      in_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && x10_wr.en) begin
      x10_bytes[x10_wr.idx] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      key_kind <= res.kind;
      key_byte <= res.key_byte;
      pointer_column <= st_next.mouse_x;
      pointer_row <= st_next.mouse_y;
    end
  end

endmodule

@@ verif/tked_tb_pkg.sv @@
`timescale 1ns / 1ps
// Checking package for the terminal escape key decoder testbench.
// Holds the word-by-word key decode model and its queue of expected key events.
// Depends on tked_pkg for the character codes, phases and key kinds.
package tked_tb_pkg;
  import tked_pkg::*;

  localparam int NO_KEY = -1;
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam int VT_HOME = 1;
  localparam int VT_DEL = 3;
  localparam int VT_END = 4;
  localparam int VT_PGUP = 5;
  localparam int VT_PGDN = 6;
  localparam int VT_HOME_ALT = 7;
  localparam int VT_END_ALT = 8;

  localparam int MOD_CTRL = 5;
  localparam int MOD_CTRL_SHIFT = 6;
  localparam int MOD_CTRL_ALT = 7;

  localparam int BTN_LEFT = 0;
  localparam int BTN_RIGHT = 2;
  localparam int BTN_ALT_LEFT = 8;
  localparam int BTN_META_LEFT = 16;
  localparam int BTN_ALT_META_LEFT = 24;
  localparam int BTN_WHEEL_UP = 64;
  localparam int BTN_WHEEL_DN = 65;

  typedef struct packed {
    key_kind_t          kind;
    logic [7:0]         key_byte;
    logic signed [16:0] column;
    logic signed [16:0] row;
  } key_event_t;

  class key_decode_model;
    phase_t             phase;
    int                 seq_len;
    logic [7:0]         first;
    logic [15:0]        num [3];
    logic [2:0]         cursor;
    logic [7:0]         stop [3];
    int                 x10_cnt;
    logic [7:0]         x10_b [2];
    logic signed [16:0] mx;
    logic signed [16:0] my;
    key_event_t         expected_keys [$];
    int                 mismatches;

    function new();
      phase = PH_IDLE;
      seq_len = 0;
      first = '0;
      num = '{default: '0};
      cursor = '0;
      stop = '{default: '0};
      x10_cnt = 0;
      x10_b = '{default: '0};
      mx = '0;
      my = '0;
      mismatches = 0;
    endfunction

    function logic [15:0] sat_digit(logic [15:0] v, logic [7:0] c);
      int r;
      r = int'(v) * 10 + int'(c) - int'(CH_ZERO);
      return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function void feed_field(logic [7:0] c, int last_field);
      int k;
      if (cursor[2]) return;
      k = cursor[1:0];
      if (k > 2) k = 2;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        num[k] = sat_digit(num[k], c);
      end else if (c == CH_SEMI && k < last_field) begin
        stop[k] = c;
        cursor = 3'(k + 1);
      end else begin
        stop[k] = c;
        cursor = {1'b1, 2'(k)};
      end
    endfunction

    function int eval_numeric();
      int k;
      logic [7:0] c;
      k = cursor[1:0];
      if (!cursor[2] || k > 1) return KEY_ESC;
      c = stop[k];
      if (k == 0) begin
        if (c != CH_TILDE) return KEY_ESC;
        case (num[0])
          VT_HOME, VT_HOME_ALT: return KEY_LINE_START;
          VT_DEL: return KEY_DEL;
          VT_END, VT_END_ALT: return KEY_END;
          VT_PGUP: return KEY_PGUP;
          VT_PGDN: return KEY_PGDN;
          default: return KEY_ESC;
        endcase
      end
      if (c == CH_TILDE && (num[1] == MOD_CTRL || num[1] == MOD_CTRL_SHIFT)) begin
        if (num[0] == VT_PGUP) return KEY_CTRL_PGUP;
        if (num[0] == VT_PGDN) return KEY_CTRL_PGDN;
      end
      if (num[1] == MOD_CTRL_ALT) begin
        if (c == CH_UPPER_A) return KEY_CTL_ALT_UP;
        if (c == CH_UPPER_B) return KEY_CTRL_ALT_DN;
      end
      if (num[1] == MOD_CTRL || num[1] == MOD_CTRL_SHIFT) begin
        if (c == CH_UPPER_C) return KEY_NEXT_WORD;
        if (c == CH_UPPER_D) return KEY_PREV_WORD;
      end
      case (c)
        CH_UPPER_A: return KEY_UP;
        CH_UPPER_B: return KEY_DOWN;
        CH_UPPER_C: return KEY_RIGHT;
        CH_UPPER_D: return KEY_LEFT;
        default: return KEY_ESC;
      endcase
    endfunction

    function int button_code(int btn, bit sgr);
      if (btn == BTN_WHEEL_UP) return KEY_WHEEL_UP;
      if (btn == BTN_WHEEL_DN) return KEY_WHEEL_DN;
      if (btn == BTN_LEFT) return KEY_CLICK_LEFT;
      if (btn == BTN_RIGHT) return KEY_CLICK_RIGHT;
      if (sgr && (btn == BTN_ALT_LEFT || btn == BTN_META_LEFT || btn == BTN_ALT_META_LEFT))
        return KEY_ALT_CLICK_LEFT;
      return NO_KEY;
    endfunction

    function int finish_csi();
      logic [7:0] fin;
      phase = PH_IDLE;
      if (seq_len == 0) return KEY_ESC;
      if (first == CH_UPPER_M && seq_len == 1) begin
        phase = PH_X10;
        x10_cnt = 0;
        return NO_KEY;
      end
      if (first == CH_LESS) begin
        fin = '0;
        if (cursor[2]) fin = stop[(cursor[1:0] > 2'd2) ? 2 : cursor[1:0]];
        if (fin != CH_UPPER_M) return NO_KEY;
        mx = $signed({1'b0, num[1]}) - 17'sd1;
        my = $signed({1'b0, num[2]}) - 17'sd1;
        return button_code(int'(num[0]), 1'b1);
      end
      if (seq_len == 1 && first >= CH_UPPER_A) begin
        case (first)
          CH_UPPER_A: return KEY_UP;
          CH_UPPER_B: return KEY_DOWN;
          CH_UPPER_C: return KEY_RIGHT;
          CH_UPPER_D: return KEY_LEFT;
          CH_UPPER_H: return KEY_LINE_START;
          CH_UPPER_F: return KEY_END;
          default: return KEY_ESC;
        endcase
      end
      return eval_numeric();
    endfunction

    function logic signed [16:0] x10_coord(logic [7:0] b);
      int v;
      v = int'(b) - int'(X10_COORD_BASE);
      return (v < 0) ? 17'sd0 : 17'(v);
    endfunction

    function int decode_word(logic op, logic [7:0] b);
      case (phase)
        PH_IDLE: begin
          if (op == OP_TIMEOUT || b == CH_NUL) return NO_KEY;
          if (b == CH_ESC) begin
            phase = PH_ESC;
            return NO_KEY;
          end
          return KEY_BYTE;
        end
        PH_ESC: begin
          phase = PH_IDLE;
          if (op == OP_TIMEOUT) return KEY_ESC;
          if (b == CH_LBRACKET) begin
            phase = PH_CSI;
            seq_len = 0;
            first = '0;
            num = '{default: '0};
            cursor = '0;
            stop = '{default: '0};
            return NO_KEY;
          end
          if (b == CH_UPPER_O) begin
            phase = PH_SS3;
            return NO_KEY;
          end
          return KEY_ESC;
        end
        PH_SS3: begin
          phase = PH_IDLE;
          if (op == OP_TIMEOUT) return KEY_ESC;
          if (b == CH_UPPER_H) return KEY_LINE_START;
          if (b == CH_UPPER_F) return KEY_END;
          if (b == CH_LOWER_C) return KEY_NEXT_WORD;
          if (b == CH_LOWER_D) return KEY_PREV_WORD;
          return KEY_ESC;
        end
        PH_CSI: begin
          if (op == OP_TIMEOUT) return finish_csi();
          if (seq_len == 0) begin
            first = b;
            if (b != CH_LESS) feed_field(b, 1);
          end else begin
            feed_field(b, (first == CH_LESS) ? 2 : 1);
          end
          seq_len++;
          if ((b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
              b == CH_TILDE || seq_len >= SEQ_MAX)
            return finish_csi();
          return NO_KEY;
        end
        PH_X10: begin
          if (op == OP_TIMEOUT) begin
            phase = PH_IDLE;
            x10_cnt = 0;
            return NO_KEY;
          end
          if (x10_cnt < 2) begin
            x10_b[x10_cnt] = b;
            x10_cnt++;
            return NO_KEY;
          end
          phase = PH_IDLE;
          x10_cnt = 0;
          mx = x10_coord(x10_b[1]);
          my = x10_coord(b);
          return button_code(int'(x10_b[0]) - int'(X10_BUTTON_BASE), 1'b0);
        end
        default: begin
          phase = PH_IDLE;
          return NO_KEY;
        end
      endcase
    endfunction

    function void take_word(logic op, logic [7:0] b);
      int kind;
      key_event_t ev;
      kind = decode_word(op, b);
      if (kind != NO_KEY) begin
        ev.kind = key_kind_t'(kind);
        ev.key_byte = (kind == KEY_BYTE) ? b : 8'h00;
        ev.column = mx;
        ev.row = my;
        expected_keys.push_back(ev);
      end
    endfunction

    function void compare_key(logic [4:0] kind, logic [7:0] kb, logic signed [16:0] col,
                              logic signed [16:0] row);
      key_event_t want;
      if (expected_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected key event: kind %0d byte %02h col %0d row %0d",
                   kind, kb, col, row);
        return;
      end
      want = expected_keys.pop_front();
      if (kind !== want.kind || kb !== want.key_byte || col !== want.column ||
          row !== want.row) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("key mismatch: expected kind %0d byte %02h col %0d row %0d,",
                   want.kind, want.key_byte, want.column, want.row);
          $display("  got kind %0d byte %02h col %0d row %0d", kind, kb, col, row);
        end
      end
    endfunction
  endclass

endpackage

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Top-level testbench for the terminal escape key decoder.
// Drives directed and random terminal byte sequences with random handshake stalls.
// Depends on tked_pkg and on the key decode model in tked_tb_pkg.
module testbench;
  import tked_pkg::*;
  import tked_tb_pkg::*;

  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_OFF_LEN = 300;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = 1'b0;
  logic [7:0]         data_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [4:0]         key_kind;
  logic [7:0]         key_byte;
  logic signed [16:0] pointer_column;
  logic signed [16:0] pointer_row;

  key_decode_model key_check;
  word_t           script [$];
  bit              idling_on = 1'b1;
  int              hold_off_cycles = 0;
  int              stuck_cycles = 0;

  terminal_escape_key_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .key_kind      (key_kind),
    .key_byte      (key_byte),
    .pointer_column(pointer_column),
    .pointer_row   (pointer_row)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic void push_byte(logic [7:0] b);
    script.push_back('{OP_BYTE, b});
  endfunction

  function automatic void push_timeout();
    script.push_back('{OP_TIMEOUT, 8'($urandom_range(0, 255))});
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_number(int n);
    push_text($sformatf("%0d", n));
  endfunction

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic int pick_button();
    case ($urandom_range(0, 7))
      0: return BTN_LEFT;
      1: return BTN_RIGHT;
      2: return BTN_WHEEL_UP;
      3: return BTN_WHEEL_DN;
      4: return BTN_ALT_LEFT;
      5: return BTN_META_LEFT;
      6: return BTN_ALT_META_LEFT;
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  function automatic int pick_coord();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99999) : $urandom_range(0, 300);
  endfunction

  // Returns the number of words queued.
  function automatic int queue_random_sequence();
    int start_size;
    int pick;
    logic [7:0] b;
    start_size = script.size();
    pick = $urandom_range(0, 11);
    case (pick)
      0: begin
        b = 8'($urandom_range(1, 255));
        push_byte(b);
        if (b == CH_ESC) push_timeout();
      end
      1: begin
        push_byte(CH_ESC);
        if ($urandom_range(0, 1)) begin
          push_timeout();
        end else begin
          push_byte(8'($urandom_range(0, 255)));
          push_timeout();
        end
      end
      2: begin
        push_byte(CH_ESC);
        push_byte(CH_UPPER_O);
        case ($urandom_range(0, 5))
          0: push_byte(CH_UPPER_H);
          1: push_byte(CH_UPPER_F);
          2: push_byte(CH_LOWER_C);
          3: push_byte(CH_LOWER_D);
          4: push_byte(8'($urandom_range(0, 255)));
          default: push_timeout();
        endcase
      end
      3: begin
        push_byte(CH_ESC);
        push_byte(CH_LBRACKET);
        push_byte(pick_char("ABCDHFZa"));
      end
      4: begin
        push_byte(CH_ESC);
        push_byte(CH_LBRACKET);
        push_number(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99999) :
                    $urandom_range(0, 9));
        push_byte(CH_TILDE);
      end
      5: begin
        push_byte(CH_ESC);
        push_byte(CH_LBRACKET);
        push_number($urandom_range(0, 9));
        push_byte(CH_SEMI);
        push_number($urandom_range(1, 8));
        push_byte(pick_char("ABCD~x"));
      end
      6: begin
        push_byte(CH_ESC);
        push_byte(CH_LBRACKET);
        push_byte(CH_UPPER_M);
        case ($urandom_range(0, 4))
          0: push_byte(8'(X10_BUTTON_BASE + BTN_LEFT));
          1: push_byte(8'(X10_BUTTON_BASE + BTN_RIGHT));
          2: push_byte(8'(X10_BUTTON_BASE + BTN_WHEEL_UP));
          3: push_byte(8'(X10_BUTTON_BASE + BTN_WHEEL_DN));
          default: push_byte(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 7) == 0) push_timeout();
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
      end
      7: begin
        push_byte(CH_ESC);
        push_byte(CH_LBRACKET);
        push_byte(CH_LESS);
        push_number(pick_button());
        push_byte(CH_SEMI);
        push_number(pick_coord());
        push_byte(CH_SEMI);
        push_number(pick_coord());
        case ($urandom_range(0, 5))
          0: push_byte(CH_LOWER_A + 8'd12);
          1: push_timeout();
          default: push_byte(CH_UPPER_M);
        endcase
      end
      8: begin
        push_byte(CH_ESC);
        push_byte(CH_LBRACKET);
        repeat (SEQ_MAX + 2) push_byte(pick_char("0123456789;"));
      end
      9: begin
        push_byte(CH_ESC);
        push_byte(CH_LBRACKET);
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
        push_timeout();
      end
      10: begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) push_timeout();
          else push_byte(8'($urandom_range(0, 255)));
        end
      end
      default: begin
        if ($urandom_range(0, 1)) push_timeout();
        else push_byte(CH_NUL);
      end
    endcase
    return script.size() - start_size;
  endfunction

  task automatic send_word(input word_t w);
    int gap;
    gap = idling_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= w.op;
    data_byte <= w.data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    key_check.take_word(w.op, w.data);
  endtask

  task automatic run_script();
    while (script.size() > 0) send_word(script.pop_front());
  endtask

  task automatic run_random(input int target);
    int counted;
    counted = 0;
    while (counted < target) begin
      counted += queue_random_sequence();
      run_script();
    end
  endtask

  task automatic drain_keys();
    in_valid <= 1'b0;
    while (key_check.expected_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_directed();
    push_byte(CH_UPPER_A);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(CH_NUL);
    push_timeout();
    push_byte(CH_ESC); push_timeout();
    push_byte(CH_ESC); push_text("x");
    push_byte(CH_ESC); push_text("OH");
    push_byte(CH_ESC); push_text("OF");
    push_byte(CH_ESC); push_text("Oc");
    push_byte(CH_ESC); push_text("Od");
    push_byte(CH_ESC); push_text("O"); push_timeout();
    push_byte(CH_ESC); push_text("Oz");
    push_byte(CH_ESC); push_text("[A");
    push_byte(CH_ESC); push_text("[H");
    push_byte(CH_ESC); push_text("["); push_timeout();
    push_byte(CH_ESC); push_text("[Z");
    push_byte(CH_ESC); push_text("[3~");
    push_byte(CH_ESC); push_text("[5;5~");
    push_byte(CH_ESC); push_text("[1;7A");
    push_byte(CH_ESC); push_text("[1;5C");
    push_byte(CH_ESC); push_text("[1;2B");
    push_byte(CH_ESC); push_text("[M"); push_byte(8'h20); push_byte(8'h21); push_byte(8'h22);
    push_byte(CH_ESC); push_text("[M"); push_byte(8'h61); push_byte(8'hFF); push_byte(8'h00);
    push_byte(CH_ESC); push_text("[Ma"); push_timeout();
    push_byte(CH_ESC); push_text("[<0;10;20M");
    push_byte(CH_ESC); push_text("[<64;1;1m");
    push_byte(CH_ESC); push_text("[<0;0;0M");
    push_byte(CH_ESC); push_text("[<99999;70000;70000M");
    push_byte(CH_ESC); push_text("[<8;5;5M");
    push_byte(CH_ESC); push_text("[");
    repeat (SEQ_MAX) push_text("9");
    push_byte(CH_ESC); push_text("[3"); push_byte(CH_NUL); push_text("~");
    push_byte(CH_ESC); push_text("[12"); push_timeout();
  endtask

  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (idling_on ? $urandom_range(0, 19) : 0) + hold_off_cycles;
      hold_off_cycles = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      key_check.compare_key(key_kind, key_byte, pointer_column, pointer_row);
    end
  end

  initial begin
    key_check = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_directed();
    run_script();
    run_random(70);

    // The receiver stops for a long stretch while words keep coming back to back.
    idling_on = 1'b0;
    hold_off_cycles = HOLD_OFF_LEN;
    run_random(70);
    drain_keys();

    idling_on = 1'b1;
    run_random(75);
    drain_keys();

    if (key_check.mismatches == 0 && key_check.expected_keys.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/tked_pkg.sv
design/tked_field.sv
design/tked_step.sv
design/terminal_escape_key_decoder.sv
verif/tked_tb_pkg.sv
verif/testbench.sv
